[rtl/upmix_pkg.sv]
// ----------------------------------------------------------------------------
// upmix_pkg: shared types and constants for the stereo upmix biquad bank
// Sample and coefficient formats, payload structs, filter routing and the
// fixed coefficient table of the low-pass, high-pass and band-pass sections.
// ----------------------------------------------------------------------------
package upmix_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int COEF_SHIFT     = 30 - COEF_FRAC_BITS;
  localparam int PROD_W         = SAMPLE_BITS + COEF_W;
  localparam int ACC_W          = PROD_W + 3;
  localparam int GAIN_W         = 5;
  localparam int NUM_CH         = 6;
  localparam int CH_W           = 3;
  localparam int TAP_W          = 3;
  localparam int CFG_IDX_W      = 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [CH_W-1:0]               ch_t;
  typedef logic [TAP_W-1:0]              tap_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_MODE = 1'd0;
  localparam cfg_idx_t REG_GAIN = 1'd1;

  localparam logic  MODE_RESET = 1'b1;
  localparam gain_t GAIN_RESET = -5'sd3;

  // channel slots, in output field order
  localparam ch_t CH_LEFT   = 3'd0;
  localparam ch_t CH_CENTER = 3'd1;
  localparam ch_t CH_BASS   = 3'd5;

  // biquad taps in accumulation order
  localparam tap_t TAP_B0 = 3'd0;
  localparam tap_t TAP_B1 = 3'd1;
  localparam tap_t TAP_B2 = 3'd2;
  localparam tap_t TAP_A1 = 3'd3;
  localparam tap_t TAP_A2 = 3'd4;

  typedef enum logic [1:0] {
    FILT_LP,
    FILT_HP,
    FILT_BP
  } filt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_center;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic signed [SAMPLE_BITS-1:0] out_left_surround;
    logic signed [SAMPLE_BITS-1:0] out_right_surround;
    logic signed [SAMPLE_BITS-1:0] out_bass;
  } out_t;

  // one history entry per channel
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  // sequencer to datapath
  typedef struct packed {
    logic  rd_en;
    ch_t   rd_ch;
    logic  mac_en;
    tap_t  tap;
    filt_t filt;
    logic  store;
  } bq_ctrl_t;

  typedef struct packed {
    filt_t filt;
    logic  use_right;
  } route_t;

  // filter type and source for each channel slot
  function automatic route_t route(logic mode, ch_t ch);
    route_t r;
    r.filt      = FILT_LP;
    r.use_right = 1'b0;
    if (mode) begin
      case (ch)
        3'd1:    begin r.filt = FILT_LP; r.use_right = 1'b0; end
        3'd2:    begin r.filt = FILT_BP; r.use_right = 1'b1; end
        3'd3:    begin r.filt = FILT_HP; r.use_right = 1'b0; end
        3'd4:    begin r.filt = FILT_BP; r.use_right = 1'b0; end
        3'd5:    begin r.filt = FILT_HP; r.use_right = 1'b1; end
        default: begin r.filt = FILT_LP; r.use_right = 1'b0; end
      endcase
    end else begin
      case (ch)
        3'd0:    begin r.filt = FILT_LP; r.use_right = 1'b0; end
        3'd1:    begin r.filt = FILT_HP; r.use_right = 1'b0; end
        3'd2:    begin r.filt = FILT_HP; r.use_right = 1'b1; end
        3'd3:    begin r.filt = FILT_BP; r.use_right = 1'b0; end
        3'd4:    begin r.filt = FILT_BP; r.use_right = 1'b1; end
        3'd5:    begin r.filt = FILT_LP; r.use_right = 1'b1; end
        default: begin r.filt = FILT_LP; r.use_right = 1'b0; end
      endcase
    end
    return r;
  endfunction

  // Q2.30 table: b0 b1 b2 a1 a2
  function automatic logic signed [31:0] coef_q30(filt_t f, tap_t k);
    logic signed [31:0] c;
    c = '0;
    case (f)
      FILT_LP: begin
        case (k)
          TAP_B0:  c = 32'sd610995363;
          TAP_B1:  c = 32'sd1221990726;
          TAP_B2:  c = 32'sd610995363;
          TAP_A1:  c = 32'sd1012330264;
          TAP_A2:  c = 32'sd357909365;
          default: c = '0;
        endcase
      end
      FILT_HP: begin
        case (k)
          TAP_B0:  c = 32'sd997101531;
          TAP_B1:  c = -32'sd1994203062;
          TAP_B2:  c = 32'sd997101531;
          TAP_A1:  c = -32'sd1988725833;
          TAP_A2:  c = 32'sd925938467;
          default: c = '0;
        endcase
      end
      FILT_BP: begin
        case (k)
          TAP_B0:  c = 32'sd399719220;
          TAP_B1:  c = 32'sd0;
          TAP_B2:  c = -32'sd399719220;
          TAP_A1:  c = -32'sd734198042;
          TAP_A2:  c = 32'sd274303385;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // reduce to Q2.COEF_FRAC_BITS, rounding half up
  function automatic coef_t coef(filt_t f, tap_t k);
    logic signed [32:0] raw;
    logic signed [32:0] rnd;
    raw = 33'(coef_q30(f, k));
    if (COEF_SHIFT == 0) begin
      rnd = raw;
    end else begin
      rnd = (raw + (33'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
    end
    return rnd[COEF_W-1:0];
  endfunction

  // clamp to the sample range
  function automatic sample_t sat(acc_t v);
    acc_t smax;
    acc_t smin;
    smax = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    smin = -smax - acc_t'(1);
    if (v > smax) begin
      return smax[SAMPLE_BITS-1:0];
    end else if (v < smin) begin
      return smin[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

[rtl/upmix_bq_core.sv]
// ----------------------------------------------------------------------------
// upmix_bq_core: shared biquad multiply-accumulate with history memory
// Holds the six channel histories in a synchronous memory, accumulates the
// five taps of one section in turn and writes the updated history back
// together with the rounded, saturated output.
// ----------------------------------------------------------------------------
module upmix_bq_core (
  input  logic                clk,
  input  logic                rst,
  input  upmix_pkg::bq_ctrl_t ctrl,
  input  upmix_pkg::sample_t  x,
  output upmix_pkg::sample_t  y
);

  localparam upmix_pkg::acc_t RND =
    upmix_pkg::acc_t'(1) <<< (upmix_pkg::COEF_FRAC_BITS - 1);

  upmix_pkg::hist_t mem [upmix_pkg::NUM_CH];
  logic [upmix_pkg::NUM_CH-1:0] hist_valid;

  upmix_pkg::hist_t rd_data;
  logic             rd_valid;
  upmix_pkg::ch_t   wr_ch;
  upmix_pkg::hist_t hist;
  upmix_pkg::hist_t wr_entry;

  upmix_pkg::coef_t                    c;
  upmix_pkg::sample_t                  s;
  logic signed [upmix_pkg::PROD_W-1:0] prod;
  upmix_pkg::acc_t                     term;
  upmix_pkg::acc_t                     acc;
  upmix_pkg::acc_t                     acc_next;
  upmix_pkg::acc_t                     rnd;

  // history memory, one read-modify-write per section
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_ch];
      wr_ch   <= ctrl.rd_ch;
    end
    if (ctrl.store) begin
      mem[wr_ch] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        rd_valid <= hist_valid[ctrl.rd_ch];
      end
      if (ctrl.store) begin
        hist_valid[wr_ch] <= 1'b1;
      end
    end
  end

  // an entry never written reads as cleared history
  assign hist = rd_valid ? rd_data : '0;

  always_comb begin
    case (ctrl.tap)
      upmix_pkg::TAP_B0: s = x;
      upmix_pkg::TAP_B1: s = hist.x1;
      upmix_pkg::TAP_B2: s = hist.x2;
      upmix_pkg::TAP_A1: s = hist.y1;
      upmix_pkg::TAP_A2: s = hist.y2;
      default:           s = '0;
    endcase
  end

  assign c    = upmix_pkg::coef(ctrl.filt, ctrl.tap);
  assign prod = upmix_pkg::PROD_W'(c) * upmix_pkg::PROD_W'(s);
  assign term = upmix_pkg::ACC_W'(prod);

  always_comb begin
    acc_next = (ctrl.tap == upmix_pkg::TAP_B0) ? '0 : acc;
    if (ctrl.tap >= upmix_pkg::TAP_A1) begin
      acc_next = acc_next - term;
    end else begin
      acc_next = acc_next + term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mac_en) begin
      acc <= acc_next;
    end
  end

  // round half up, scale back to sample format, clamp
  assign rnd = (acc + RND) >>> upmix_pkg::COEF_FRAC_BITS;
  assign y   = upmix_pkg::sat(rnd);

  // shift the history by one sample
  assign wr_entry.x1 = x;
  assign wr_entry.x2 = hist.x1;
  assign wr_entry.y1 = y;
  assign wr_entry.y2 = hist.y1;

`ifndef SYNTHESIS
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    ctrl.store && ctrl.rd_en |-> ctrl.rd_ch != wr_ch)
    else $error("history read and write-back hit the same entry");

  a_fetch_before_store: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |=> !ctrl.store)
    else $error("write-back directly after a history fetch");

  a_mac_not_store: assert property (@(posedge clk) disable iff (rst)
    ctrl.store |=> !$past(ctrl.mac_en) || ctrl.mac_en || !ctrl.store)
    else $error("accumulate and write-back overlap");
`endif

endmodule

[rtl/stereo_upmix_biquad_bank_unit.sv]
// ----------------------------------------------------------------------------
// stereo_upmix_biquad_bank_unit: stereo to six-channel upmix with biquads
// Applies a signed integer gain to a stereo frame and derives six channels from
// low-pass, high-pass and band-pass direct form I sections; mode 1 skips left.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one stereo frame per transfer;
//   output channel out_valid/out_ready carries the six channel samples.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 = mode, 1 = gain) at once; write only while the block is idle.
//   One multiplier serves all sections: each section accumulates its five
//   taps and then writes back, with the history fetch of the next section
//   overlapping the write-back.
//   Mode 1 runs five sections (center to bass), mode 0 all six. A new
//   frame is taken only after the previous one has moved to the output
//   register.
//   A finished frame waits in the output register while the next frame is
//   taken and filtered; if the receiver still stalls when that frame is
//   done, the sequencer holds until the output register is free.
//   Reset clears all filter histories (through per-channel valid bits),
//   sets mode to 1 and gain to -3, and empties the output register.
// ----------------------------------------------------------------------------
module stereo_upmix_biquad_bank_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  upmix_pkg::in_t       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output upmix_pkg::out_t      out_data,
  input  logic                 cfg_we,
  input  upmix_pkg::cfg_idx_t  cfg_index,
  input  upmix_pkg::gain_t     cfg_data
);

  localparam int GP_W = upmix_pkg::SAMPLE_BITS + upmix_pkg::GAIN_W;

  upmix_pkg::state_t   state;
  upmix_pkg::state_t   state_next;
  logic                mode;
  upmix_pkg::gain_t    gain;
  upmix_pkg::ch_t      ch;
  upmix_pkg::tap_t     tap;
  upmix_pkg::sample_t  l_g;
  upmix_pkg::sample_t  r_g;
  upmix_pkg::sample_t  res [upmix_pkg::NUM_CH];
  upmix_pkg::route_t   rt;
  upmix_pkg::bq_ctrl_t ctrl;
  upmix_pkg::sample_t  bq_x;
  upmix_pkg::sample_t  bq_y;
  logic                in_xfer;
  logic                out_free;
  logic                load_out;

  function automatic upmix_pkg::sample_t gain_apply(upmix_pkg::sample_t s,
                                                    upmix_pkg::gain_t g);
    logic signed [GP_W-1:0] p;
    p = GP_W'(s) * GP_W'(g);
    return upmix_pkg::sat(upmix_pkg::ACC_W'(p));
  endfunction

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rt       = upmix_pkg::route(mode, ch);
  assign bq_x     = rt.use_right ? r_g : l_g;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= upmix_pkg::MODE_RESET;
      gain <= upmix_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        upmix_pkg::REG_MODE: mode <= cfg_data[0];
        upmix_pkg::REG_GAIN: gain <= cfg_data;
        default:             ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      upmix_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = upmix_pkg::ST_FETCH;
        end
      end
      upmix_pkg::ST_FETCH: state_next = upmix_pkg::ST_MAC;
      upmix_pkg::ST_MAC: begin
        if (tap == upmix_pkg::TAP_A2) begin
          state_next = upmix_pkg::ST_STORE;
        end
      end
      upmix_pkg::ST_STORE: begin
        if (ch == upmix_pkg::CH_BASS) begin
          state_next = upmix_pkg::ST_DONE;
        end else begin
          state_next = upmix_pkg::ST_MAC;
        end
      end
      upmix_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = upmix_pkg::ST_IDLE;
        end
      end
      default: state_next = upmix_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    load_out    = 1'b0;
    ctrl.rd_en  = 1'b0;
    ctrl.rd_ch  = ch;
    ctrl.mac_en = 1'b0;
    ctrl.tap    = tap;
    ctrl.filt   = rt.filt;
    ctrl.store  = 1'b0;
    case (state)
      upmix_pkg::ST_IDLE:  in_ready = 1'b1;
      upmix_pkg::ST_FETCH: ctrl.rd_en = 1'b1;
      upmix_pkg::ST_MAC:   ctrl.mac_en = 1'b1;
      upmix_pkg::ST_STORE: begin
        ctrl.store = 1'b1;
        // fetch the next section's history during write-back
        if (ch != upmix_pkg::CH_BASS) begin
          ctrl.rd_en = 1'b1;
          ctrl.rd_ch = upmix_pkg::ch_t'(ch + 1'b1);
        end
      end
      upmix_pkg::ST_DONE:  load_out = out_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upmix_pkg::ST_IDLE;
      ch    <= upmix_pkg::CH_LEFT;
      tap   <= upmix_pkg::TAP_B0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        ch <= mode ? upmix_pkg::CH_CENTER : upmix_pkg::CH_LEFT;
      end else if (ctrl.store) begin
        ch <= upmix_pkg::ch_t'(ch + 1'b1);
      end
      if (ctrl.mac_en) begin
        tap <= upmix_pkg::tap_t'(tap + 1'b1);
      end else begin
        tap <= upmix_pkg::TAP_B0;
      end
    end
  end

  // gained samples, held for the whole frame
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      l_g <= gain_apply(in_data.left_sample, gain);
      r_g <= gain_apply(in_data.right_sample, gain);
    end
    if (ctrl.store) begin
      res[ch] <= bq_y;
    end
  end

  upmix_bq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .x    (bq_x),
    .y    (bq_y)
  );

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.out_left           <= mode ? l_g : res[0];
      out_data.out_center         <= res[1];
      out_data.out_right          <= res[2];
      out_data.out_left_surround  <= res[3];
      out_data.out_right_surround <= res[4];
      out_data.out_bass           <= res[5];
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == upmix_pkg::ST_FETCH)
    else $error("frame transfer did not start a fetch");

  a_last_section: assert property (@(posedge clk) disable iff (rst)
    state == upmix_pkg::ST_STORE && ch == upmix_pkg::CH_BASS
      |=> state == upmix_pkg::ST_DONE)
    else $error("sequencer ran past the last section");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == upmix_pkg::ST_DONE)
    else $error("output raised outside frame completion");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == upmix_pkg::ST_MAC |-> tap <= upmix_pkg::TAP_A2)
    else $error("tap counter out of range");
`endif

endmodule

[test/upmix_frame_checker.sv]
// ----------------------------------------------------------------------------
// upmix_frame_checker: frame predictor and scoreboard for the upmix bank
// Follows register writes and accepted stereo frames, computes the six
// expected channel samples with its own copy of the filter histories, and
// compares every output transfer field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module upmix_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  upmix_pkg::in_t      in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  upmix_pkg::out_t     out_data,
  input  logic                cfg_we,
  input  upmix_pkg::cfg_idx_t cfg_index,
  input  upmix_pkg::gain_t    cfg_data,
  output logic                busy,
  output int                  errors
);

  // history slots, in output field order
  localparam int SLOT_LEFT     = 0;
  localparam int SLOT_CENTER   = 1;
  localparam int SLOT_RIGHT    = 2;
  localparam int SLOT_LSUR     = 3;
  localparam int SLOT_RSUR     = 4;
  localparam int SLOT_BASS     = 5;

  longint          x_d1 [upmix_pkg::NUM_CH];
  longint          x_d2 [upmix_pkg::NUM_CH];
  longint          y_d1 [upmix_pkg::NUM_CH];
  longint          y_d2 [upmix_pkg::NUM_CH];
  logic            cur_mode;
  longint          cur_gain;
  upmix_pkg::out_t pending_frames [$];
  int              frames_seen;

  function automatic longint tap_q30(upmix_pkg::filt_t f, upmix_pkg::tap_t k);
    case (f)
      upmix_pkg::FILT_LP: begin
        case (k)
          upmix_pkg::TAP_B0: return 610995363;
          upmix_pkg::TAP_B1: return 1221990726;
          upmix_pkg::TAP_B2: return 610995363;
          upmix_pkg::TAP_A1: return 1012330264;
          default:           return 357909365;
        endcase
      end
      upmix_pkg::FILT_HP: begin
        case (k)
          upmix_pkg::TAP_B0: return 997101531;
          upmix_pkg::TAP_B1: return -1994203062;
          upmix_pkg::TAP_B2: return 997101531;
          upmix_pkg::TAP_A1: return -1988725833;
          default:           return 925938467;
        endcase
      end
      default: begin
        case (k)
          upmix_pkg::TAP_B0: return 399719220;
          upmix_pkg::TAP_B1: return 0;
          upmix_pkg::TAP_B2: return -399719220;
          upmix_pkg::TAP_A1: return -734198042;
          default:           return 274303385;
        endcase
      end
    endcase
  endfunction

  // round the Q2.30 table half up to the working fraction width
  function automatic longint fixed_tap(upmix_pkg::filt_t f, upmix_pkg::tap_t k);
    int     s;
    longint raw;
    s   = 30 - upmix_pkg::COEF_FRAC_BITS;
    raw = tap_q30(f, k);
    if (s == 0) begin
      return raw;
    end
    return (raw + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (upmix_pkg::SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // direct form I section; the sum is kept in 64 bits, wider than the hardware accumulator
  function automatic upmix_pkg::sample_t run_section(longint x, upmix_pkg::filt_t f,
                                                     int ch);
    longint acc;
    longint y;
    acc = fixed_tap(f, upmix_pkg::TAP_B0) * x
        + fixed_tap(f, upmix_pkg::TAP_B1) * x_d1[ch]
        + fixed_tap(f, upmix_pkg::TAP_B2) * x_d2[ch]
        - fixed_tap(f, upmix_pkg::TAP_A1) * y_d1[ch]
        - fixed_tap(f, upmix_pkg::TAP_A2) * y_d2[ch];
    acc += longint'(1) <<< (upmix_pkg::COEF_FRAC_BITS - 1);
    y = clamp(acc >>> upmix_pkg::COEF_FRAC_BITS);
    x_d2[ch] = x_d1[ch];
    x_d1[ch] = x;
    y_d2[ch] = y_d1[ch];
    y_d1[ch] = y;
    return upmix_pkg::sample_t'(y);
  endfunction

  function automatic upmix_pkg::out_t predict_frame(upmix_pkg::in_t f);
    longint          l;
    longint          r;
    upmix_pkg::out_t o;
    l = clamp(longint'(f.left_sample) * cur_gain);
    r = clamp(longint'(f.right_sample) * cur_gain);
    if (cur_mode) begin
      // left passes straight through; its history is left alone
      o.out_left           = upmix_pkg::sample_t'(l);
      o.out_center         = run_section(l, upmix_pkg::FILT_LP, SLOT_CENTER);
      o.out_left_surround  = run_section(l, upmix_pkg::FILT_HP, SLOT_LSUR);
      o.out_right_surround = run_section(l, upmix_pkg::FILT_BP, SLOT_RSUR);
      o.out_right          = run_section(r, upmix_pkg::FILT_BP, SLOT_RIGHT);
      o.out_bass           = run_section(r, upmix_pkg::FILT_HP, SLOT_BASS);
    end else begin
      o.out_left           = run_section(l, upmix_pkg::FILT_LP, SLOT_LEFT);
      o.out_center         = run_section(l, upmix_pkg::FILT_HP, SLOT_CENTER);
      o.out_left_surround  = run_section(l, upmix_pkg::FILT_BP, SLOT_LSUR);
      o.out_right_surround = run_section(r, upmix_pkg::FILT_BP, SLOT_RSUR);
      o.out_right          = run_section(r, upmix_pkg::FILT_HP, SLOT_RIGHT);
      o.out_bass           = run_section(r, upmix_pkg::FILT_LP, SLOT_BASS);
    end
    return o;
  endfunction

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, upmix_pkg::sample_t got,
                             upmix_pkg::sample_t want);
    if (got !== want) begin
      report($sformatf("frame %0d %s: got %0d, want %0d", frames_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    upmix_pkg::out_t want;
    if (rst) begin
      for (int c = 0; c < upmix_pkg::NUM_CH; c++) begin
        x_d1[c] = 0;
        x_d2[c] = 0;
        y_d1[c] = 0;
        y_d2[c] = 0;
      end
      cur_mode = upmix_pkg::MODE_RESET;
      cur_gain = longint'(upmix_pkg::GAIN_RESET);
      pending_frames.delete();
      frames_seen = 0;
      busy <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          upmix_pkg::REG_MODE: cur_mode = cfg_data[0];
          upmix_pkg::REG_GAIN: cur_gain = longint'(cfg_data);
          default:             ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          report($sformatf("output transfer with no frame outstanding"));
        end else begin
          want = pending_frames.pop_front();
          check_field("out_left", out_data.out_left, want.out_left);
          check_field("out_center", out_data.out_center, want.out_center);
          check_field("out_right", out_data.out_right, want.out_right);
          check_field("out_left_surround", out_data.out_left_surround,
                      want.out_left_surround);
          check_field("out_right_surround", out_data.out_right_surround,
                      want.out_right_surround);
          check_field("out_bass", out_data.out_bass, want.out_bass);
        end
        frames_seen++;
      end
      if (in_valid && in_ready) begin
        pending_frames.push_back(predict_frame(in_data));
      end
      busy <= (pending_frames.size() != 0);
    end
  end

endmodule

[test/stereo_upmix_biquad_bank_unit_test.sv]
// ----------------------------------------------------------------------------
// stereo_upmix_biquad_bank_unit_test: top level of the upmix bank bench
// Drives stereo frames and register writes into the block under three
// stall patterns, leaves prediction and comparison to the frame checker,
// and gives the verdict from its failure count and outstanding frames.
// ----------------------------------------------------------------------------
module stereo_upmix_biquad_bank_unit_test;

  localparam int QUIET_LIMIT    = 1000;
  localparam int TAIL_CYCLES    = 50;
  localparam int SEGMENTS       = 4;
  localparam int FRAMES_PER_SEG = 58;
  localparam upmix_pkg::sample_t FULL_POS =
    upmix_pkg::sample_t'((1 << (upmix_pkg::SAMPLE_BITS - 1)) - 1);
  localparam upmix_pkg::sample_t FULL_NEG =
    upmix_pkg::sample_t'(-(1 << (upmix_pkg::SAMPLE_BITS - 1)));

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  upmix_pkg::in_t      in_data;
  logic                out_valid;
  logic                out_ready;
  upmix_pkg::out_t     out_data;
  logic                cfg_we;
  upmix_pkg::cfg_idx_t cfg_index;
  upmix_pkg::gain_t    cfg_data;
  logic                model_busy;
  int                  mismatches;

  int send_idle_pct = 28;
  int recv_idle_pct = 62;
  int quiet_cycles  = 0;
  int frames_sent   = 0;
  int settings_used = 0;

  stereo_upmix_biquad_bank_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  upmix_frame_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (model_busy),
    .errors    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_frame(upmix_pkg::sample_t l, upmix_pkg::sample_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_sample: l, right_sample: r};
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  // drop valid and hold until every predicted frame has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (model_busy);
  endtask

  task automatic set_config(logic m, upmix_pkg::gain_t g);
    cfg_we    <= 1'b1;
    cfg_index <= upmix_pkg::REG_MODE;
    cfg_data  <= upmix_pkg::gain_t'(m);
    @(posedge clk);
    cfg_index <= upmix_pkg::REG_GAIN;
    cfg_data  <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic upmix_pkg::sample_t pick_sample();
    upmix_pkg::sample_t v;
    v = upmix_pkg::sample_t'($urandom);
    case ($urandom_range(9))
      0:       v = FULL_POS;
      1:       v = FULL_NEG;
      2:       v = '0;
      3, 4, 5: v = v >>> $urandom_range(upmix_pkg::SAMPLE_BITS - 2);
      default: ;
    endcase
    return v;
  endfunction

  // mostly the intended range, now and then any 5-bit value
  function automatic upmix_pkg::gain_t pick_gain();
    if ($urandom_range(4) == 0) begin
      return upmix_pkg::gain_t'($urandom_range(31));
    end
    return upmix_pkg::gain_t'(0 - int'($urandom_range(16)));
  endfunction

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = upmix_pkg::REG_MODE;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: mode 1 (left passed through), gain of minus three
    send_frame(FULL_POS, FULL_NEG);
    send_frame(FULL_NEG, FULL_POS);
    send_frame(0, 0);
    send_frame(1, -1);
    send_frame(24'sh100000, -24'sh100000);
    send_frame(0, 0);
    send_frame(0, 0);
    settle();

    // strongest gain, all channels filtered; histories carry over
    set_config(1'b0, -5'sd16);
    send_frame(FULL_POS, FULL_POS);
    send_frame(FULL_NEG, FULL_NEG);
    send_frame(-1, 1);
    send_frame(0, 0);
    send_frame(0, 0);
    settle();

    set_config(1'b1, 5'sd0);
    send_frame(FULL_POS, FULL_NEG);
    send_frame(12345, -54321);
    settle();

    // positive gain beyond the intended range saturates
    set_config(1'b0, 5'sd15);
    send_frame(FULL_POS, FULL_NEG);
    send_frame(24'sh080000, -24'sh080000);
    send_frame(0, 0);
    settle();

    // minus one on the most negative sample clamps to the top
    set_config(1'b1, -5'sd1);
    send_frame(FULL_NEG, FULL_NEG);
    send_frame(0, 0);
    settle();

    set_config(1'b0, 5'sd1);
    send_frame(24'sh400000, 24'sh3FFFFF);
    send_frame(0, 0);
    send_frame(0, 0);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 28; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        set_config(1'($urandom_range(1)), pick_gain());
        for (int n = 0; n < FRAMES_PER_SEG; n++) begin
          send_frame(pick_sample(), pick_sample());
        end
        settle();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d stereo frames through %0d mode and gain settings,",
             frames_sent, settings_used);
    $display("gain extremes, saturation and histories across mode changes included.");
    if (mismatches == 0 && !model_busy) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[stereo_upmix_biquad_bank_unit.f]
rtl/upmix_pkg.sv
rtl/upmix_bq_core.sv
rtl/stereo_upmix_biquad_bank_unit.sv
test/upmix_frame_checker.sv
test/stereo_upmix_biquad_bank_unit_test.sv
